// ----- design/bkwd_pkg.sv -----
// Package for the block keyed word decryptor: widths, key and chaining
// constants, configuration register indexes and the shared structs.
// No dependencies.
`timescale 1ns / 1ps

package bkwd_pkg;

  localparam int unsigned MAX_BLOCK_WORDS = 16384;
  localparam int unsigned POS_W           = $clog2(MAX_BLOCK_WORDS);
  localparam int unsigned LEN_W           = 15;
  localparam int unsigned WORD_W          = 32;

  localparam logic [LEN_W-1:0] MIN_LEN     = LEN_W'(2);
  localparam logic [LEN_W-1:0] MAX_LEN     = LEN_W'(MAX_BLOCK_WORDS);
  localparam logic [LEN_W-1:0] RESET_LEN   = LEN_W'(4096);

  localparam logic [WORD_W-1:0] KEY_CHAIN_A = 32'h0000_5CA8;
  localparam logic [WORD_W-1:0] KEY_CHAIN_B = 32'h0000_D13F;

  localparam logic [WORD_W-1:0] CHAIN_SUB_A = 32'h50A4_A89D;
  localparam logic [WORD_W-1:0] CHAIN_SUB_B = 32'h3AF7_0BC4;
  localparam logic [WORD_W-1:0] CHAIN_ADD_C = 32'h0709_1971;
  localparam logic [WORD_W-1:0] CHAIN_SUB_D = 32'h11E6_7319;
  localparam logic [WORD_W-1:0] LOW_MASK    = 32'h0000_FFFF;

  // Configuration register indexes.
  localparam logic CFG_CIPHER_KEY      = 1'b0;
  localparam logic CFG_WORDS_PER_BLOCK = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]  word_position;
    logic              past_first_block;
    logic [WORD_W-1:0] previous_cipher;
    logic [WORD_W-1:0] running_sum;
  } blk_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] plain_word;
    logic              is_check_slot;
    logic              check_failed;
  } result_t;

endpackage

// ----- design/bkwd_if.sv -----
// Request and result channel interfaces of the block keyed word decryptor.
// No dependencies.
`timescale 1ns / 1ps

interface bkwd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_word;
  logic        stream_start;

  modport source (output valid, output cipher_word, output stream_start, input ready);
  modport sink   (input valid, input cipher_word, input stream_start, output ready);
endinterface

interface bkwd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] plain_word;
  logic        is_check_slot;
  logic        check_failed;

  modport source (output valid, output plain_word, output is_check_slot,
                  output check_failed, input ready);
  modport sink   (input valid, input plain_word, input is_check_slot,
                  input check_failed, output ready);
endinterface

// ----- design/block_keyed_word_decryptor_core.sv -----
// Block keyed word decryptor: one decrypted result per ciphertext request,
// one request a cycle while the result queue has room. One pass of decode
// logic sits between an input register and a two-entry result queue, so a
// full queue never stalls the request side combinationally. Each request is
// registered in the input stage, then written to the queue, raising result
// valid. Sustained rate is one word per cycle while the sink keeps up, set by
// the single state update per word. Depends on bkwd_pkg, bkwd_if, bkwd_step.
`timescale 1ns / 1ps

module block_keyed_word_decryptor_core
  import bkwd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [WORD_W-1:0]  cfg_wdata_i,
  bkwd_in_if.sink            req_in_i,
  bkwd_out_if.source         res_out_o
);

  logic [WORD_W-1:0] key_q;
  logic [LEN_W-1:0]  len_q;

  logic              s1_valid_q;
  logic [WORD_W-1:0] s1_word_q;
  logic              s1_start_q;

  blk_state_t        state_q;
  blk_state_t        state_d;
  result_t           step_res;

  result_t           fifo_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        count_q;

  logic              fifo_room;
  logic              s1_adv;
  logic              in_acc;
  logic              out_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      len_q <= RESET_LEN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CIPHER_KEY:      key_q <= cfg_wdata_i;
        CFG_WORDS_PER_BLOCK: len_q <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign fifo_room      = (count_q != 2'd2);
  assign s1_adv         = s1_valid_q && fifo_room;
  assign req_in_i.ready = !s1_valid_q || fifo_room;
  assign in_acc         = req_in_i.valid && req_in_i.ready;
  assign out_acc        = res_out_o.valid && res_out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_in_i.ready) begin
      s1_valid_q <= req_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q  <= req_in_i.cipher_word;
      s1_start_q <= req_in_i.stream_start;
    end
  end

  bkwd_step u_step (
    .state_i           (state_q),
    .cipher_word_i     (s1_word_q),
    .stream_start_i    (s1_start_q),
    .cipher_key_i      (key_q),
    .words_per_block_i (len_q),
    .state_o           (state_d),
    .result_o          (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // Result queue: written as the input stage drains, read by the sink.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fifo_q[wr_ptr_q] <= step_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (s1_adv) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_acc) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, s1_adv} - {1'b0, out_acc};
    end
  end

  assign res_out_o.valid         = (count_q != 2'd0);
  assign res_out_o.plain_word    = fifo_q[rd_ptr_q].plain_word;
  assign res_out_o.is_check_slot = fifo_q[rd_ptr_q].is_check_slot;
  assign res_out_o.check_failed  = fifo_q[rd_ptr_q].check_failed;

endmodule

// ----- design/bkwd_step.sv -----
// Combinational decode of one word: block position, key or chained decode,
// running sum and checksum compare. Depends on bkwd_pkg.
`timescale 1ns / 1ps

module bkwd_step
  import bkwd_pkg::*;
(
  input  blk_state_t        state_i,
  input  logic [WORD_W-1:0] cipher_word_i,
  input  logic              stream_start_i,
  input  logic [WORD_W-1:0] cipher_key_i,
  input  logic [LEN_W-1:0]  words_per_block_i,
  output blk_state_t        state_o,
  output result_t           result_o
);

  blk_state_t        cur;
  logic [LEN_W-1:0]  blk_len;
  logic              at_check;
  logic              chained;
  logic [WORD_W-1:0] prev;
  logic [WORD_W-1:0] kw;
  logic [WORD_W-1:0] c;
  logic [WORD_W-1:0] chain_plain;
  logic [WORD_W-1:0] plain;

  // A stream start wipes all state before this word is used.
  assign cur = stream_start_i ? '0 : state_i;

  always_comb begin
    if (words_per_block_i < MIN_LEN) begin
      blk_len = MIN_LEN;
    end else if (words_per_block_i > MAX_LEN) begin
      blk_len = MAX_LEN;
    end else begin
      blk_len = words_per_block_i;
    end
  end

  // Any position at or past the last slot closes the block.
  assign at_check = {1'b0, cur.word_position} >= (blk_len - LEN_W'(1));

  assign chained = cur.past_first_block &&
                   ((cipher_key_i == KEY_CHAIN_A) || (cipher_key_i == KEY_CHAIN_B));

  assign prev = cur.previous_cipher;
  assign c    = cipher_word_i;

  always_comb begin
    case (prev[17:16])
      2'd0:    kw = prev - CHAIN_SUB_A;
      2'd1:    kw = CHAIN_SUB_B - prev;
      2'd2:    kw = {prev[30:0] + CHAIN_ADD_C[30:0], 1'b0};
      default: kw = {CHAIN_SUB_D[30:0] - prev[30:0], 1'b0};
    endcase
  end

  always_comb begin
    case (c[1:0])
      2'd0:    chain_plain = ~c ^ kw;
      2'd1:    chain_plain = c ^ kw;
      2'd2:    chain_plain = c ^ ~kw;
      default: chain_plain = c ^ kw ^ LOW_MASK;
    endcase
  end

  assign plain = chained ? chain_plain : (c ^ cipher_key_i);

  always_comb begin
    state_o  = cur;
    result_o = '0;
    if (at_check) begin
      result_o.is_check_slot   = 1'b1;
      result_o.check_failed    = (c != cur.running_sum);
      state_o.past_first_block = 1'b1;
      state_o.word_position    = '0;
      state_o.previous_cipher  = '0;
      state_o.running_sum      = '0;
    end else begin
      result_o.plain_word   = plain;
      state_o.running_sum   = cur.running_sum + plain;
      state_o.word_position = cur.word_position + POS_W'(1);
      if (chained) begin
        state_o.previous_cipher = c;
      end
    end
  end

endmodule

// ----- tb/tb_block_keyed_word_decryptor_core.sv -----
// Self-checking testbench for block_keyed_word_decryptor_core: a directed table
// and random blocks are checked against an in-bench decryption predictor.
// Depends on bkwd_pkg, bkwd_if and the core itself.
`timescale 1ns / 1ps

module tb_block_keyed_word_decryptor_core;
  import bkwd_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 1700;
  localparam int unsigned PHASE_WORDS    = 580;
  localparam int unsigned TIMEOUT_CYCLES = 200_000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned N_ROWS         = 28;

  typedef enum logic [1:0] {ROW_WORD, ROW_SUM, ROW_KEY, ROW_LEN} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [WORD_W-1:0] word;
    logic              start;
    logic              typed;
    logic [WORD_W-1:0] exp_plain;
    logic              exp_slot;
    logic              exp_fail;
  } stim_row_t;

  // ROW_SUM sends the running sum at the checksum slot; ROW_KEY and ROW_LEN
  // write the value held in the word column.
  stim_row_t stim_rows [N_ROWS] = '{
    '{ROW_WORD, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{ROW_WORD, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
    '{ROW_WORD, 32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678, 1'b0, 1'b0},
    '{ROW_LEN,  32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_WORD, 32'h1234_5678, 1'b0, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{ROW_WORD, 32'h0000_0001, 1'b0, 1'b1, 32'h0000_0001, 1'b0, 1'b0},
    '{ROW_WORD, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b1, 1'b1},
    '{ROW_KEY,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_WORD, 32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{ROW_WORD, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{ROW_LEN,  32'h0000_0004, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_KEY,  KEY_CHAIN_A,   1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_WORD, 32'h0000_0000, 1'b1, 1'b1, KEY_CHAIN_A,   1'b0, 1'b0},
    '{ROW_WORD, 32'hAAAA_0001, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_WORD, 32'h5A5A_A5A5, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_SUM,  32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_WORD, 32'h0002_0000, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_WORD, 32'h0003_0001, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_WORD, 32'h0001_0002, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_SUM,  32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_WORD, 32'h0001_0003, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_KEY,  KEY_CHAIN_B,   1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_LEN,  32'(MAX_LEN),  1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_WORD, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_LEN,  32'(MIN_LEN),  1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_WORD, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_LEN,  32'h0000_7FFF, 1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
    '{ROW_WORD, 32'h8000_0002, 1'b1, 1'b1, 32'h8000_0002 ^ KEY_CHAIN_B, 1'b0, 1'b0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [WORD_W-1:0] cfg_wdata_i;

  bkwd_in_if  req_if ();
  bkwd_out_if res_if ();

  block_keyed_word_decryptor_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_in_i    (req_if),
    .res_out_o   (res_if)
  );

  // Predictor copy of the registers and the block state.
  logic [WORD_W-1:0] key_q         = '0;
  logic [LEN_W-1:0]  len_q         = RESET_LEN;
  logic [POS_W-1:0]  pos_q         = '0;
  logic              past_first_q  = 1'b0;
  logic [WORD_W-1:0] prev_cipher_q = '0;
  logic [WORD_W-1:0] sum_q         = '0;

  result_t expected_plain_q [$];

  int unsigned snd_idle_pct = 19;
  int unsigned rcv_idle_pct = 51;
  int unsigned sent_cnt     = 0;
  int unsigned res_cnt      = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned cfg_cnt      = 0;
  int unsigned n_check      = 0;
  int unsigned n_bad_check  = 0;
  int unsigned n_chained    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [LEN_W-1:0] clamped_len();
    logic [LEN_W-1:0] n;
    n = len_q;
    if (n < MIN_LEN) n = MIN_LEN;
    if (n > MAX_LEN) n = MAX_LEN;
    return n;
  endfunction

  function automatic logic at_check_slot();
    return LEN_W'(pos_q) >= clamped_len() - LEN_W'(1);
  endfunction

  function automatic void clear_block_state();
    pos_q         = '0;
    prev_cipher_q = '0;
    sum_q         = '0;
  endfunction

  // Works out the result of one accepted request and advances the state.
  function automatic result_t decrypt_and_advance(input logic [WORD_W-1:0] word,
                                                  input logic start);
    result_t           res;
    logic [WORD_W-1:0] k;
    res = '0;
    if (start) begin
      past_first_q = 1'b0;
      clear_block_state();
    end
    if (at_check_slot()) begin
      res.is_check_slot = 1'b1;
      res.check_failed  = (word != sum_q);
      n_check++;
      if (res.check_failed) n_bad_check++;
      past_first_q = 1'b1;
      clear_block_state();
    end else begin
      if (past_first_q && (key_q == KEY_CHAIN_A || key_q == KEY_CHAIN_B)) begin
        // The key word follows from the previous ciphertext word of the block.
        case (prev_cipher_q[17:16])
          2'd0:    k = prev_cipher_q - CHAIN_SUB_A;
          2'd1:    k = CHAIN_SUB_B - prev_cipher_q;
          2'd2:    k = (prev_cipher_q + CHAIN_ADD_C) << 1;
          default: k = (CHAIN_SUB_D - prev_cipher_q) << 1;
        endcase
        case (word[1:0])
          2'd0:    res.plain_word = ~word ^ k;
          2'd1:    res.plain_word = ~word ^ ~k;
          2'd2:    res.plain_word = word ^ ~k;
          default: res.plain_word = word ^ k ^ LOW_MASK;
        endcase
        prev_cipher_q = word;
        n_chained++;
      end else begin
        res.plain_word = word ^ key_q;
      end
      sum_q = sum_q + res.plain_word;
      pos_q = pos_q + 1'b1;
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("mismatch: %s on result %0d at cycle %0d, expected %h, got %h",
               what, res_cnt, cycle_cnt, want, got);
  endtask

  task automatic send_word(input logic [WORD_W-1:0] word, input logic start,
                           input logic typed, input result_t typed_res);
    result_t res;
    if (sent_cnt < PHASE_WORDS) begin
      snd_idle_pct = 19;
      rcv_idle_pct = 51;
    end else if (sent_cnt < 2 * PHASE_WORDS) begin
      snd_idle_pct = 51;
      rcv_idle_pct = 19;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cipher_word  <= word;
    req_if.stream_start <= start;
    do @(posedge clk_i); while (!req_if.ready);
    res = decrypt_and_advance(word, start);
    expected_plain_q.push_back(typed ? typed_res : res);
    sent_cnt++;
  endtask

  // Holds requests back until every outstanding result has been taken.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_plain_q.size() != 0);
  endtask

  task automatic write_registers(input logic do_key, input logic [WORD_W-1:0] key,
                                 input logic do_len, input logic [LEN_W-1:0] len);
    drain_results();
    if (do_key) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_CIPHER_KEY;
      cfg_wdata_i <= key;
      @(posedge clk_i);
      key_q = key;
      cfg_cnt++;
    end
    if (do_len) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_WORDS_PER_BLOCK;
      cfg_wdata_i <= WORD_W'(len);
      @(posedge clk_i);
      len_q = len;
      cfg_cnt++;
    end
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random back-pressure and comparison with the oldest expectation.
  initial begin
    result_t want;
    result_t got;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.plain_word    = res_if.plain_word;
        got.is_check_slot = res_if.is_check_slot;
        got.check_failed  = res_if.check_failed;
        if (expected_plain_q.size() == 0) begin
          note_mismatch("result with nothing expected", '0, got.plain_word);
        end else begin
          want = expected_plain_q.pop_front();
          if (got.plain_word !== want.plain_word)
            note_mismatch("plain_word", want.plain_word, got.plain_word);
          if (got.is_check_slot !== want.is_check_slot)
            note_mismatch("is_check_slot", want.is_check_slot, got.is_check_slot);
          if (got.check_failed !== want.check_failed)
            note_mismatch("check_failed", want.check_failed, got.check_failed);
        end
        res_cnt++;
      end
      res_if.ready <= rst_ni && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    while (cycle_cnt < TIMEOUT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles with %0d results outstanding",
             cycle_cnt, expected_plain_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    stim_row_t         row;
    result_t           typed_res;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
    logic              start;
    logic              restart;
    int unsigned       seg_words;
    int unsigned       r;
    int unsigned       target;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_CIPHER_KEY;
    cfg_wdata_i         <= '0;
    req_if.valid        <= 1'b0;
    req_if.cipher_word  <= '0;
    req_if.stream_start <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: extremes, length clamping, each chained form, mid-block changes.
    for (int i = 0; i < N_ROWS; i++) begin
      row = stim_rows[i];
      typed_res.plain_word    = row.exp_plain;
      typed_res.is_check_slot = row.exp_slot;
      typed_res.check_failed  = row.exp_fail;
      case (row.kind)
        ROW_WORD: send_word(row.word, row.start, row.typed, typed_res);
        ROW_SUM:  send_word(sum_q, 1'b0, 1'b0, typed_res);
        ROW_KEY:  write_registers(1'b1, row.word, 1'b0, '0);
        default:  write_registers(1'b0, '0, 1'b1, row.word[LEN_W-1:0]);
      endcase
    end

    // Random segments: mostly well-formed blocks with good checksums, chained keys
    // favoured, short blocks for most words and the largest lengths now and then.
    target = sent_cnt + RANDOM_WORDS;
    while (sent_cnt < target) begin
      r = $urandom_range(9);
      if (r < 4) key = KEY_CHAIN_A;
      else if (r < 7) key = KEY_CHAIN_B;
      else if (r == 7) key = $urandom();
      else if (r == 8) key = '0;
      else key = '1;
      r = $urandom_range(19);
      if (r == 0) begin
        case ($urandom_range(4))
          0:       len = '0;
          1:       len = LEN_W'(1);
          2:       len = MAX_LEN;
          3:       len = '1;
          default: len = MAX_LEN - LEN_W'(1);
        endcase
      end else if (r < 4) begin
        len = LEN_W'($urandom_range(40, 13));
      end else begin
        len = LEN_W'($urandom_range(12, 2));
      end
      write_registers($urandom_range(9) < 7, key, $urandom_range(9) < 7, len);
      seg_words = (clamped_len() > LEN_W'(40)) ? $urandom_range(30, 10)
                                               : $urandom_range(120, 40);
      restart = ($urandom_range(9) < 3);
      repeat (seg_words) begin
        start   = restart || ($urandom_range(99) < 2);
        restart = 1'b0;
        if (!start && at_check_slot())
          word = ($urandom_range(99) < 85) ? sum_q : $urandom();
        else
          word = $urandom();
        send_word(word, start, 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (expected_plain_q.size() != 0) begin
      mismatch_cnt += expected_plain_q.size();
      $display("%0d expected results never arrived", expected_plain_q.size());
    end
    $display("Sent %0d words over %0d register writes: %0d checksum slots (%0d failing),",
             sent_cnt, cfg_cnt, n_check, n_bad_check);
    $display("%0d words in chained mode, %0d results checked, %0d mismatches.",
             n_chained, res_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
